// File: rtl/core/lennard_jones_pair_force_unit_assert.svh
// ----------------------------------------------------------------------------
// Lennard-Jones pair force unit: assertion macros
// Shared concurrent assertion forms used by the core modules.
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_PAIR_FORCE_UNIT_ASSERT_SVH
`define LENNARD_JONES_PAIR_FORCE_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LJPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lennard_jones_pair_force_unit: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LJPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lennard_jones_pair_force_unit: assertion failed");

// The expression is never true.
`define LJPF_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("lennard_jones_pair_force_unit: assertion failed");

`endif

// File: rtl/core/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg
// Types, constants and saturating helpers for the Lennard-Jones pair force unit.
// ----------------------------------------------------------------------------
package ljpf_pkg;

	localparam int MAX_ATOMS_DEF = 4096;

	localparam logic [1:0] CFG_REPULSIVE  = 2'd0;
	localparam logic [1:0] CFG_ATTRACTIVE = 2'd1;
	localparam logic [1:0] CFG_CUTOFF     = 2'd2;
	localparam logic [1:0] CFG_BOX        = 2'd3;

	localparam logic [47:0] REPULSIVE_RST  = 48'd262144;
	localparam logic [47:0] ATTRACTIVE_RST = 48'd262144;
	localparam logic [31:0] CUTOFF_RST     = 32'd2359296;
	localparam logic [30:0] BOX_RST        = 31'd655360;

	localparam logic [47:0] POS48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG48 = 48'h8000_0000_0000;
	// Largest value whose twelvefold still fits in 64 bits.
	localparam logic [63:0] B12_LIMIT = 64'h1555_5555_5555_5555;

	typedef struct packed {
		logic [11:0] home_atom;
		logic [11:0] other_atom;
		logic signed [31:0] home_x;
		logic signed [31:0] home_y;
		logic signed [31:0] home_z;
		logic signed [31:0] other_x;
		logic signed [31:0] other_y;
		logic signed [31:0] other_z;
		logic last_neighbour;
		logic start_of_step;
	} in_item_t;

	typedef struct packed {
		logic [11:0] atom_index;
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [47:0] total_energy;
	} out_item_t;

	typedef struct packed {
		logic [47:0] repulsive_coeff;
		logic [47:0] attractive_coeff;
		logic [31:0] cutoff_squared;
		logic [30:0] box_length;
	} cfg_t;

	// One classified pair handed from the front to the back.
	typedef struct packed {
		logic valid_pair;
		logic [11:0] home_atom;
		logic [2:0][23:0] mag;
		logic [2:0] neg;
		logic [49:0] dist_sq;
		logic last;
		logic start;
	} pair_t;

	function automatic logic signed [33:0] wrap_f(logic signed [33:0] d, logic [30:0] box);
		logic signed [33:0] box_s;
		logic signed [33:0] half_s;
		box_s  = $signed({3'b000, box});
		half_s = $signed({4'b0000, box[30:1]});
		if (d > half_s) begin
			return d - box_s;
		end else if (d < -half_s) begin
			return d + box_s;
		end
		return d;
	endfunction

	function automatic logic [47:0] clamp48(logic neg, logic [63:0] mag);
		if (neg) begin
			return (mag >= 64'h8000_0000_0000) ? NEG48 : 48'd0 - mag[47:0];
		end
		return (mag >= 64'h7FFF_FFFF_FFFF) ? POS48 : mag[47:0];
	endfunction

	function automatic logic [47:0] add48(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47]) begin
			return s[48] ? NEG48 : POS48;
		end
		return s[47:0];
	endfunction

endpackage

// File: rtl/core/ljpf_front.sv
// ----------------------------------------------------------------------------
// ljpf_front
// Accepts pair requests, wraps the distance, forms the squared distance and
// classifies the pair before handing it to the queue.
// ----------------------------------------------------------------------------
module ljpf_front import ljpf_pkg::*; #(
	parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  cfg_t     cfg,
	input  logic     q_full,
	output logic     q_push,
	output pair_t    q_data
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_WRAP = 4'b0010,
		F_SQ   = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t         state_q;
	in_item_t        item_q;
	logic [23:0]     mag_q [3];
	logic [2:0]      neg_q;
	logic            big_q;
	logic [49:0]     s_q;
	logic [1:0]      cnt_q;

	logic signed [33:0] diff [3];
	logic signed [33:0] wr [3];
	logic [33:0]        absd [3];
	logic [47:0]        sq;
	logic               idx_ok;

	assign in_stall = (state_q != F_IDLE);

	always_comb begin
		diff[0] = $signed({{2{item_q.home_x[31]}}, item_q.home_x})
			- $signed({{2{item_q.other_x[31]}}, item_q.other_x});
		diff[1] = $signed({{2{item_q.home_y[31]}}, item_q.home_y})
			- $signed({{2{item_q.other_y[31]}}, item_q.other_y});
		diff[2] = $signed({{2{item_q.home_z[31]}}, item_q.home_z})
			- $signed({{2{item_q.other_z[31]}}, item_q.other_z});
		for (int i = 0; i < 3; i++) begin
			wr[i]   = wrap_f(diff[i], cfg.box_length);
			absd[i] = wr[i][33] ? 34'(-wr[i]) : 34'(wr[i]);
		end
	end

	assign sq = mag_q[cnt_q] * mag_q[cnt_q];

	assign idx_ok = (32'(item_q.home_atom) < MAX_ATOMS) && (32'(item_q.other_atom) < MAX_ATOMS)
		&& (item_q.home_atom != item_q.other_atom);

	always_comb begin
		q_data.valid_pair = idx_ok && !big_q && (s_q != 50'd0)
			&& (s_q < {2'b00, cfg.cutoff_squared, 16'd0});
		q_data.home_atom  = item_q.home_atom;
		q_data.mag[0]     = mag_q[0];
		q_data.mag[1]     = mag_q[1];
		q_data.mag[2]     = mag_q[2];
		q_data.neg        = neg_q;
		q_data.dist_sq    = s_q;
		q_data.last       = item_q.last_neighbour;
		q_data.start      = item_q.start_of_step;
	end

	assign q_push = (state_q == F_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_WRAP;
					end
				end
				F_WRAP: begin
					cnt_q   <= 2'd0;
					state_q <= F_SQ;
				end
				F_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == F_WRAP) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= absd[i][23:0];
				neg_q[i] <= wr[i][33];
			end
			big_q <= (|absd[0][33:24]) || (|absd[1][33:24]) || (|absd[2][33:24]);
			s_q   <= 50'd0;
		end
		if (state_q == F_SQ) begin
			s_q <= s_q + 50'(sq);
		end
	end

endmodule

// File: rtl/core/ljpf_queue.sv
// ----------------------------------------------------------------------------
// ljpf_queue
// Two-entry queue of classified pairs between the front and the back.
// ----------------------------------------------------------------------------
`include "lennard_jones_pair_force_unit_assert.svh"

module ljpf_queue import ljpf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  pair_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output pair_t pop_data
);

	pair_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	`LJPF_ASSERT_NEVER(a_q_overflow, clk, arst_n, push && full && !pop)
	`LJPF_ASSERT_NEVER(a_q_underflow, clk, arst_n, pop && !not_empty)
	`LJPF_ASSERT_NEVER(a_q_count, clk, arst_n, cnt_q == 2'd3)

endmodule

// File: rtl/core/ljpf_back.sv
// ----------------------------------------------------------------------------
// ljpf_back
// Works through one classified pair at a time: reciprocal by restoring
// division, the force and energy terms on a shared 32x32 multiplier, and the
// saturating accumulators and result register.
// ----------------------------------------------------------------------------
`include "lennard_jones_pair_force_unit_assert.svh"

module ljpf_back import ljpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  pair_t     q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_DIV  = 6'b000010,
		B_LOAD = 6'b000100,
		B_MUL  = 6'b001000,
		B_MRES = 6'b010000,
		B_FIN  = 6'b100000
	} bstate_t;

	localparam logic [3:0] OP_R2  = 4'd0;
	localparam logic [3:0] OP_R6  = 4'd1;
	localparam logic [3:0] OP_P12 = 4'd2;
	localparam logic [3:0] OP_EN  = 4'd3;
	localparam logic [3:0] OP_T   = 4'd4;
	localparam logic [3:0] OP_FF  = 4'd5;
	localparam logic [3:0] OP_FX  = 4'd6;
	localparam logic [3:0] OP_FY  = 4'd7;
	localparam logic [3:0] OP_FZ  = 4'd8;

	localparam logic [1:0] SH16 = 2'd0;
	localparam logic [1:0] SH24 = 2'd1;
	localparam logic [1:0] SH32 = 2'd2;
	localparam logic [1:0] SH33 = 2'd3;

	bstate_t     state_q;
	pair_t       entry_q;
	logic [3:0]  op_q;
	logic [2:0]  k_q;
	logic [5:0]  cnt_q;
	logic [49:0] rem_q;
	logic [63:0] rinv_q;
	logic [63:0] a_q, b_q;
	logic [1:0]  sh_q;
	logic [63:0] prod_s1;
	logic [127:0] acc_q;
	logic [63:0] r2_q, r6_q, p12_q, t_q, ffac_q;
	logic [47:0] fx_q, fy_q, fz_q, atom_energy_q, energy_total_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [50:0]  trial;
	logic         qbit;
	logic [63:0]  c6q, b12, b6, em, fm;
	logic         eneg, fneg;
	logic [63:0]  a_sel, b_sel;
	logic [1:0]   sh_sel;
	logic [31:0]  a_part, b_part;
	logic [127:0] addend;
	logic [63:0]  res;
	logic         out_free;
	logic         emit;
	logic [47:0]  energy_next;

	assign trial = {rem_q, 1'b1};
	assign qbit  = (trial >= {1'b0, entry_q.dist_sq});

	assign c6q  = {8'd0, cfg.attractive_coeff, 8'd0};
	assign b12  = (p12_q > B12_LIMIT) ? '1 : (p12_q << 3) + (p12_q << 2);
	assign b6   = (c6q << 2) + (c6q << 1);
	assign eneg = (p12_q < c6q);
	assign em   = eneg ? c6q - p12_q : p12_q - c6q;
	assign fneg = (b12 < b6);
	assign fm   = fneg ? b6 - b12 : b12 - b6;

	always_comb begin
		a_sel  = rinv_q;
		b_sel  = rinv_q;
		sh_sel = SH32;
		case (op_q)
			OP_R2:  begin a_sel = rinv_q; b_sel = rinv_q; sh_sel = SH32; end
			OP_R6:  begin a_sel = r2_q; b_sel = rinv_q; sh_sel = SH32; end
			OP_P12: begin a_sel = {16'd0, cfg.repulsive_coeff}; b_sel = r6_q; sh_sel = SH24; end
			OP_EN:  begin a_sel = em; b_sel = r6_q; sh_sel = SH33; end
			OP_T:   begin a_sel = fm; b_sel = r6_q; sh_sel = SH32; end
			OP_FF:  begin a_sel = t_q; b_sel = rinv_q; sh_sel = SH32; end
			OP_FX:  begin a_sel = {40'd0, entry_q.mag[0]}; b_sel = ffac_q; sh_sel = SH16; end
			OP_FY:  begin a_sel = {40'd0, entry_q.mag[1]}; b_sel = ffac_q; sh_sel = SH16; end
			OP_FZ:  begin a_sel = {40'd0, entry_q.mag[2]}; b_sel = ffac_q; sh_sel = SH16; end
			default: begin a_sel = rinv_q; b_sel = rinv_q; sh_sel = SH32; end
		endcase
	end

	// Partial products in the order low-low, low-high, high-low, high-high.
	assign a_part = k_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = k_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (k_q)
			3'd1:    addend = {64'd0, prod_s1};
			3'd2:    addend = {32'd0, prod_s1, 32'd0};
			3'd3:    addend = {32'd0, prod_s1, 32'd0};
			3'd4:    addend = {prod_s1, 64'd0};
			default: addend = 128'd0;
		endcase
	end

	always_comb begin
		case (sh_q)
			SH16:    res = (|acc_q[127:80]) ? '1 : acc_q[79:16];
			SH24:    res = (|acc_q[127:88]) ? '1 : acc_q[87:24];
			SH32:    res = (|acc_q[127:96]) ? '1 : acc_q[95:32];
			SH33:    res = (|acc_q[127:97]) ? '1 : acc_q[96:33];
			default: res = '1;
		endcase
	end

	assign q_pop       = (state_q == B_IDLE) && q_valid;
	assign out_free    = !out_valid_q || !out_stall;
	assign emit        = (state_q == B_FIN) && entry_q.last && out_free;
	assign energy_next = add48(energy_total_q, atom_energy_q);
	assign out_valid   = out_valid_q;
	assign out_item    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			op_q           <= OP_R2;
			k_q            <= 3'd0;
			cnt_q          <= 6'd0;
			fx_q           <= 48'd0;
			fy_q           <= 48'd0;
			fz_q           <= 48'd0;
			atom_energy_q  <= 48'd0;
			energy_total_q <= 48'd0;
			out_valid_q    <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_data.start) begin
							energy_total_q <= 48'd0;
						end
						cnt_q   <= 6'd0;
						state_q <= q_data.valid_pair ? B_DIV : B_FIN;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						op_q    <= OP_R2;
						state_q <= B_LOAD;
					end
				end
				B_LOAD: begin
					k_q     <= 3'd0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= B_MRES;
					end
				end
				B_MRES: begin
					case (op_q)
						OP_EN: atom_energy_q <= add48(atom_energy_q, clamp48(eneg, res));
						OP_FX: fx_q <= add48(fx_q, clamp48(entry_q.neg[0] != fneg, res));
						OP_FY: fy_q <= add48(fy_q, clamp48(entry_q.neg[1] != fneg, res));
						OP_FZ: fz_q <= add48(fz_q, clamp48(entry_q.neg[2] != fneg, res));
						default: ;
					endcase
					if (op_q == OP_FZ) begin
						state_q <= B_FIN;
					end else begin
						op_q    <= op_q + 4'd1;
						state_q <= B_LOAD;
					end
				end
				B_FIN: begin
					if (!entry_q.last) begin
						state_q <= B_IDLE;
					end else if (out_free) begin
						energy_total_q <= energy_next;
						fx_q           <= 48'd0;
						fy_q           <= 48'd0;
						fz_q           <= 48'd0;
						atom_energy_q  <= 48'd0;
						state_q        <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			entry_q <= q_data;
			rem_q   <= 50'd0;
		end
		if (state_q == B_DIV) begin
			rem_q  <= qbit ? 50'(trial - {1'b0, entry_q.dist_sq}) : trial[49:0];
			rinv_q <= {rinv_q[62:0], qbit};
		end
		if (state_q == B_LOAD) begin
			a_q   <= a_sel;
			b_q   <= b_sel;
			sh_q  <= sh_sel;
			acc_q <= 128'd0;
		end
		if (state_q == B_MUL) begin
			prod_s1 <= a_part * b_part;
			acc_q   <= acc_q + addend;
		end
		if (state_q == B_MRES) begin
			case (op_q)
				OP_R2:   r2_q   <= res;
				OP_R6:   r6_q   <= res;
				OP_P12:  p12_q  <= res;
				OP_T:    t_q    <= res;
				OP_FF:   ffac_q <= res;
				default: ;
			endcase
		end
		if (emit) begin
			out_q.atom_index   <= entry_q.home_atom;
			out_q.force_x      <= fx_q;
			out_q.force_y      <= fy_q;
			out_q.force_z      <= fz_q;
			out_q.total_energy <= energy_next;
		end
	end

	`LJPF_ASSERT_NEXT(a_fin_emits, clk, arst_n,
		state_q == B_FIN && entry_q.last && out_free, out_valid_q)
	`LJPF_ASSERT_IMPL(a_div_only_valid, clk, arst_n, state_q == B_DIV, entry_q.valid_pair)
	`LJPF_ASSERT_NEXT(a_last_op_ends, clk, arst_n,
		state_q == B_MRES && op_q == OP_FZ, state_q == B_FIN)

endmodule

// File: rtl/core/lennard_jones_pair_force_unit.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_unit
// Lennard-Jones 12-6 pair force with cutoff and periodic wrap, accumulating
// per-atom force and total energy in saturating Q24.24.
//
//   channel   direction  handshake            payload
//   in        to unit    in_valid / in_stall  in_item (in_item_t)
//   out       from unit  out_valid/out_stall  out_item (out_item_t)
//   cfg       to unit    cfg_write            cfg_index, cfg_data
//
// The front takes one request at a time and holds in_stall through wrap,
// three squarings and hand-off. The back sends a pair outside the cutoff
// straight to its final step, and an interacting pair through a 64-step
// restoring divider and nine passes through the one 32x32 multiplier.
// A two-entry queue lets the front run ahead while the back is busy; a
// stalled result holds the back in its final step, not the front.
// Reset clears the accumulators, the queue and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_unit import ljpf_pkg::*; #(
	parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_push, q_full, q_pop, q_valid;
	pair_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repulsive_coeff  <= REPULSIVE_RST;
			cfg_q.attractive_coeff <= ATTRACTIVE_RST;
			cfg_q.cutoff_squared   <= CUTOFF_RST;
			cfg_q.box_length       <= BOX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_REPULSIVE:  cfg_q.repulsive_coeff  <= cfg_data;
				CFG_ATTRACTIVE: cfg_q.attractive_coeff <= cfg_data;
				CFG_CUTOFF:     cfg_q.cutoff_squared   <= cfg_data[31:0];
				CFG_BOX:        cfg_q.box_length       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	ljpf_front #(
		.MAX_ATOMS(MAX_ATOMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	ljpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	ljpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
